/* sv/gsa_pkg.sv */
// Shared types and constants for the generational slot allocator.
// Holds field widths, operation and status codes, FSM states and the
// controller/datapath command and status structs. No dependencies.
package gsa_pkg;

  // Field widths
  localparam int MODE_W = 2;
  localparam int SLOT_W = 10;
  localparam int GEN_W  = 32;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;
  localparam int REV_W  = 32;

  // Operation codes; any other code acts as check
  localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_STALE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Generation given to a never-used slot and after a wrap
  localparam logic [GEN_W-1:0] GEN_FIRST = 32'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_POP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle, issue table reads
    logic issue_pop;  // read the slot popped off the free stack
    logic commit;     // update state and load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_pop;   // held item is a create and the free stack is not empty
    logic out_free;   // result register can take a new result
  } dp_stat_t;

endpackage

/* sv/gsa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the slot table and the free stack. No dependencies.
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/gsa_ctrl.sv */
// Controller FSM of the generational slot allocator: sequences accept,
// table read, optional free-stack pop and commit. Depends on gsa_pkg.
module gsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  gsa_pkg::dp_stat_t   stat,
  output gsa_pkg::ctrl_cmd_t  cmd
);

  gsa_pkg::state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gsa_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = gsa_pkg::ST_EVAL;
      end
      gsa_pkg::ST_EVAL: begin
        if (stat.need_pop) state_nxt = gsa_pkg::ST_POP;
        else if (stat.out_free) state_nxt = gsa_pkg::ST_IDLE;
      end
      gsa_pkg::ST_POP: begin
        if (stat.out_free) state_nxt = gsa_pkg::ST_IDLE;
      end
      default: state_nxt = gsa_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready     = 1'b0;
    cmd.accept    = 1'b0;
    cmd.issue_pop = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      gsa_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      gsa_pkg::ST_EVAL: begin
        cmd.issue_pop = stat.need_pop;
        cmd.commit    = !stat.need_pop && stat.out_free;
      end
      gsa_pkg::ST_POP: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

/* sv/gsa_datapath.sv */
// Datapath of the generational slot allocator: slot table and free stack
// memories, counters, handle check and the result register.
// Depends on gsa_pkg and gsa_ram.
module gsa_datapath #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gsa_pkg::ctrl_cmd_t          cmd,
  output gsa_pkg::dp_stat_t           stat,
  input  logic [gsa_pkg::MODE_W-1:0]  in_mode,
  input  logic [gsa_pkg::SLOT_W-1:0]  in_slot,
  input  logic [gsa_pkg::GEN_W-1:0]   in_gen,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gsa_pkg::STAT_W-1:0]  out_status,
  output logic [gsa_pkg::SLOT_W-1:0]  out_slot,
  output logic [gsa_pkg::GEN_W-1:0]   out_gen,
  output logic [gsa_pkg::CNT_W-1:0]   out_live,
  output logic [gsa_pkg::REV_W-1:0]   out_rev
);

  localparam int SW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW     = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W  = (CW > gsa_pkg::SLOT_W) ? CW : gsa_pkg::SLOT_W;
  localparam int ENT_W  = gsa_pkg::GEN_W + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SLOTS);

  // Held item
  logic [gsa_pkg::MODE_W-1:0] mode_r;
  logic [gsa_pkg::SLOT_W-1:0] slot_r;
  logic [gsa_pkg::GEN_W-1:0]  gen_r;

  // Allocator state
  logic [CW-1:0]             free_top_r, free_top_nxt;
  logic [CW-1:0]             used_r, used_nxt;
  logic [CW-1:0]             alive_r, alive_nxt;
  logic [gsa_pkg::REV_W-1:0] rev_r, rev_nxt;

  // Result register
  logic                        out_valid_r;
  logic [gsa_pkg::STAT_W-1:0]  status_r, status_nxt;
  logic [gsa_pkg::SLOT_W-1:0]  oslot_r, oslot_nxt;
  logic [gsa_pkg::GEN_W-1:0]   ogen_r, ogen_nxt;
  logic [gsa_pkg::CNT_W-1:0]   live_r;
  logic [gsa_pkg::REV_W-1:0]   orev_r;

  // Memory ports
  logic             tab_we, tab_re;
  logic [SW-1:0]    tab_waddr, tab_raddr;
  logic [ENT_W-1:0] tab_wdata, tab_rdata;
  logic             stk_we;
  logic [SW-1:0]    stk_waddr, stk_raddr;
  logic [SW-1:0]    stk_rdata;

  // Decode
  logic                       is_create, is_destroy, pop_avail;
  logic                       in_range, live;
  logic                       rd_alive;
  logic [gsa_pkg::GEN_W-1:0]  rd_gen, cur_gen, bump_gen;

  // Slot table entry: alive bit over generation
  gsa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SLOTS)) u_slot_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  gsa_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_free_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (SW'(slot_r)),
    .re    (cmd.accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Latch the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      slot_r <= in_slot;
      gen_r  <= in_gen;
    end
  end

  // Handle check against the table entry read at accept
  assign rd_alive   = tab_rdata[ENT_W-1];
  assign rd_gen     = tab_rdata[gsa_pkg::GEN_W-1:0];
  assign is_create  = (mode_r == gsa_pkg::MODE_CREATE);
  assign is_destroy = (mode_r == gsa_pkg::MODE_DESTROY);
  assign pop_avail  = (free_top_r != '0);
  assign in_range   = CMP_W'(slot_r) < CMP_W'(used_r);
  assign live       = in_range && rd_alive && (rd_gen == gen_r);
  assign cur_gen    = in_range ? rd_gen : '0;
  assign bump_gen   = (rd_gen + 1'b1 == '0) ? gsa_pkg::GEN_FIRST : rd_gen + 1'b1;

  // Reads: table at the handle's slot on accept, at the popped slot after
  assign tab_re    = cmd.accept || cmd.issue_pop;
  assign tab_raddr = cmd.accept ? SW'(in_slot) : stk_rdata;
  assign stk_raddr = SW'(free_top_r - 1'b1);

  assign stat.need_pop = is_create && pop_avail;
  assign stat.out_free = !out_valid_r || out_ready;

  // Next allocator state, table and stack writes, result fields
  always_comb begin
    free_top_nxt = free_top_r;
    used_nxt     = used_r;
    alive_nxt    = alive_r;
    rev_nxt      = rev_r;
    tab_we       = 1'b0;
    tab_waddr    = SW'(slot_r);
    tab_wdata    = {1'b0, bump_gen};
    stk_we       = 1'b0;
    stk_waddr    = SW'(free_top_r);
    status_nxt   = gsa_pkg::STAT_OK;
    oslot_nxt    = slot_r;
    ogen_nxt     = cur_gen;
    if (is_create) begin
      if (pop_avail) begin
        // Reuse the most recently freed slot
        free_top_nxt = free_top_r - 1'b1;
        alive_nxt    = alive_r + 1'b1;
        rev_nxt      = rev_r + 1'b1;
        tab_we       = cmd.commit;
        tab_waddr    = stk_rdata;
        tab_wdata    = {1'b1, rd_gen};
        oslot_nxt    = gsa_pkg::SLOT_W'(stk_rdata);
        ogen_nxt     = rd_gen;
      end else if (used_r < CNT_MAX) begin
        // Take the next never-used slot
        used_nxt  = used_r + 1'b1;
        alive_nxt = alive_r + 1'b1;
        rev_nxt   = rev_r + 1'b1;
        tab_we    = cmd.commit;
        tab_waddr = SW'(used_r);
        tab_wdata = {1'b1, gsa_pkg::GEN_FIRST};
        oslot_nxt = gsa_pkg::SLOT_W'(used_r);
        ogen_nxt  = gsa_pkg::GEN_FIRST;
      end else begin
        status_nxt = gsa_pkg::STAT_FULL;
        oslot_nxt  = '0;
        ogen_nxt   = '0;
      end
    end else if (is_destroy) begin
      if (live) begin
        // Retire the slot: bump generation, push onto the free stack
        tab_we   = cmd.commit;
        ogen_nxt = bump_gen;
        rev_nxt  = rev_r + 1'b1;
        if (free_top_r < CNT_MAX) begin
          stk_we       = cmd.commit;
          free_top_nxt = free_top_r + 1'b1;
        end
        if (alive_r != '0) alive_nxt = alive_r - 1'b1;
      end else begin
        status_nxt = gsa_pkg::STAT_STALE;
      end
    end else begin
      status_nxt = live ? gsa_pkg::STAT_OK : gsa_pkg::STAT_STALE;
    end
  end

  // Update allocator state on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_top_r <= '0;
      used_r     <= '0;
      alive_r    <= '0;
      rev_r      <= '0;
    end else if (cmd.commit) begin
      free_top_r <= free_top_nxt;
      used_r     <= used_nxt;
      alive_r    <= alive_nxt;
      rev_r      <= rev_nxt;
    end
  end

  // Result valid: set on commit, drop on output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      oslot_r  <= oslot_nxt;
      ogen_r   <= ogen_nxt;
      live_r   <= gsa_pkg::CNT_W'(alive_nxt);
      orev_r   <= rev_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_slot   = oslot_r;
  assign out_gen    = ogen_r;
  assign out_live   = live_r;
  assign out_rev    = orev_r;

endmodule

/* sv/generational_slot_allocator_top.sv */
// Generational slot allocator: streams operations in, one result out each.
// Top level; depends on gsa_pkg, gsa_ctrl, gsa_datapath (and gsa_ram).
//
// Usage:
//   Input channel (in_*): one operation per transfer. mode 0 creates a
//   handle, mode 1 destroys the handle (slot_index, generation), mode 2
//   checks whether that handle is live.
//   Output channel (out_*): exactly one result per operation, in order:
//   status, handle slot and generation, live count after the operation and
//   the revision count.
//   Result: out_tvalid rises on the commit, from ST_EVAL, or from ST_POP
//   for a create that reuses a slot from the free stack (the popped slot's
//   table entry takes one more registered read). Flow: a new operation is
//   taken only in ST_IDLE, once the last one has committed; the registered
//   table read must finish before the commit.
//   Reset (rst_n low, synchronous) empties the table: no slot used, free
//   stack empty, live count and revision zero. No clearing pass is needed.
//   Stall: the result register holds while out_tready is low; the next
//   operation may be taken meanwhile, but it does not commit until the
//   held result is transferred.
module generational_slot_allocator_top #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] mode, [11:2] slot_index, [43:12] generation, [47:44] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [11:2] handle_slot, [43:12] handle_generation,
  // [54:44] live_count, [86:55] revision, [87] zero
  output logic [87:0] out_tdata
);

  gsa_pkg::ctrl_cmd_t cmd;
  gsa_pkg::dp_stat_t  stat;

  logic [gsa_pkg::STAT_W-1:0] res_status;
  logic [gsa_pkg::SLOT_W-1:0] res_slot;
  logic [gsa_pkg::GEN_W-1:0]  res_gen;
  logic [gsa_pkg::CNT_W-1:0]  res_live;
  logic [gsa_pkg::REV_W-1:0]  res_rev;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gsa_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (in_tdata[1:0]),
    .in_slot    (in_tdata[11:2]),
    .in_gen     (in_tdata[43:12]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_slot   (res_slot),
    .out_gen    (res_gen),
    .out_live   (res_live),
    .out_rev    (res_rev)
  );

  // Pack result fields, lowest first
  assign out_tdata = {1'b0, res_rev, res_live, res_gen, res_slot, res_status};

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for generational_slot_allocator_top.
// Holds a handle-table scoreboard class that predicts each result and
// checks it in order; depends on gsa_pkg and the allocator RTL.

class handle_table_scoreboard;

  localparam int TABLE_SLOTS = 1024;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [gsa_pkg::STAT_W-1:0] status;
    logic [gsa_pkg::SLOT_W-1:0] slot;
    logic [gsa_pkg::GEN_W-1:0]  gen;
    logic [gsa_pkg::CNT_W-1:0]  live;
    logic [gsa_pkg::REV_W-1:0]  rev;
  } alloc_result_t;

  // Mirror of the allocator table
  bit [gsa_pkg::GEN_W-1:0]  gen_table [TABLE_SLOTS];
  bit                       alive     [TABLE_SLOTS];
  bit [gsa_pkg::SLOT_W-1:0] free_stack[TABLE_SLOTS];
  int                       free_top;
  int                       slots_used;
  int                       alive_total;
  bit [gsa_pkg::REV_W-1:0]  revision;

  alloc_result_t            pending_results[$];
  int                       errors;

  // Coverage tallies for the closing summary
  int n_create, n_reuse, n_full, n_destroy, n_stale, n_live_check, peak_live;

  function new();
    foreach (alive[i]) begin
      alive[i]     = 1'b0;
      gen_table[i] = '0;
      free_stack[i] = '0;
    end
    free_top    = 0;
    slots_used  = 0;
    alive_total = 0;
    revision    = '0;
    errors      = 0;
  endfunction

  function bit is_live(bit [gsa_pkg::SLOT_W-1:0] s, bit [gsa_pkg::GEN_W-1:0] g);
    return (int'(s) < slots_used) && alive[s] && (gen_table[s] == g);
  endfunction

  function bit [gsa_pkg::GEN_W-1:0] current_gen(bit [gsa_pkg::SLOT_W-1:0] s);
    return (int'(s) < slots_used) ? gen_table[s] : '0;
  endfunction

  // Pick a live handle, scanning from a random start
  function bit pick_live(output bit [gsa_pkg::SLOT_W-1:0] s,
                         output bit [gsa_pkg::GEN_W-1:0] g);
    int start;
    int idx;
    s = '0;
    g = '0;
    if (alive_total == 0) return 1'b0;
    start = $urandom_range(0, slots_used - 1);
    for (int i = 0; i < slots_used; i++) begin
      idx = (start + i) % slots_used;
      if (alive[idx]) begin
        s = idx[gsa_pkg::SLOT_W-1:0];
        g = gen_table[idx];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one accepted operation to the mirror and queue its result
  function void note_request(bit [gsa_pkg::MODE_W-1:0] mode,
                             bit [gsa_pkg::SLOT_W-1:0] s,
                             bit [gsa_pkg::GEN_W-1:0] g);
    alloc_result_t r;
    int idx;
    bit [gsa_pkg::GEN_W-1:0] next_gen;
    r.status = gsa_pkg::STAT_OK;
    r.slot   = s;
    r.gen    = '0;
    idx      = 0;
    if (mode == gsa_pkg::MODE_CREATE) begin
      if (free_top > 0) begin
        free_top--;
        idx = int'(free_stack[free_top]);
        n_reuse++;
      end else if (slots_used < TABLE_SLOTS) begin
        idx = slots_used;
        slots_used++;
        gen_table[idx] = gsa_pkg::GEN_FIRST;
      end else begin
        idx = -1;
      end
      if (idx >= 0) begin
        alive[idx] = 1'b1;
        alive_total++;
        revision++;
        r.slot = idx[gsa_pkg::SLOT_W-1:0];
        r.gen  = gen_table[idx];
        n_create++;
      end else begin
        r.status = gsa_pkg::STAT_FULL;
        r.slot   = '0;
        n_full++;
      end
    end else if (mode == gsa_pkg::MODE_DESTROY) begin
      if (is_live(s, g)) begin
        next_gen = gen_table[s] + 1;
        if (next_gen == '0) next_gen = gsa_pkg::GEN_FIRST;
        gen_table[s] = next_gen;
        alive[s]     = 1'b0;
        free_stack[free_top] = s;
        free_top++;
        alive_total--;
        revision++;
        r.gen = next_gen;
        n_destroy++;
      end else begin
        r.status = gsa_pkg::STAT_STALE;
        r.gen    = current_gen(s);
        n_stale++;
      end
    end else begin
      // Check, and the spare code behaves the same
      if (is_live(s, g)) n_live_check++;
      else n_stale++;
      r.status = is_live(s, g) ? gsa_pkg::STAT_OK : gsa_pkg::STAT_STALE;
      r.gen    = current_gen(s);
    end
    r.live = alive_total[gsa_pkg::CNT_W-1:0];
    r.rev  = revision;
    if (alive_total > peak_live) peak_live = alive_total;
    pending_results.push_back(r);
  endfunction

  task report(string msg);
    if (errors < PRINT_CAP) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Compare one transferred result with the oldest expectation
  task check_response(logic [87:0] d);
    alloc_result_t e;
    if (pending_results.size() == 0) begin
      report($sformatf("result with nothing expected, data %h", d));
      return;
    end
    e = pending_results.pop_front();
    if (d[1:0] !== e.status)
      report($sformatf("status got %0d exp %0d", d[1:0], e.status));
    if (d[11:2] !== e.slot)
      report($sformatf("handle_slot got %0d exp %0d", d[11:2], e.slot));
    if (d[43:12] !== e.gen)
      report($sformatf("handle_generation got %h exp %h", d[43:12], e.gen));
    if (d[54:44] !== e.live)
      report($sformatf("live_count got %0d exp %0d", d[54:44], e.live));
    if (d[86:55] !== e.rev)
      report($sformatf("revision got %0d exp %0d", d[86:55], e.rev));
  endtask

  function int pending();
    return pending_results.size();
  endfunction

endclass

module tb_top;

  localparam int TABLE_SLOTS = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [gsa_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;

  handle_table_scoreboard sb = new();

  bit hold_req  = 1'b0;
  bit no_idle   = 1'b0;
  int hold_runs = 0;
  int cycles    = 0;

  generational_slot_allocator_top #(.MAX_SLOTS(TABLE_SLOTS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one operation, hold until its transfer, then idle a while unless the gap is zero
  task automatic send_op(input logic [gsa_pkg::MODE_W-1:0] mode,
                         input logic [gsa_pkg::SLOT_W-1:0] s,
                         input logic [gsa_pkg::GEN_W-1:0] g);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, g, s, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(mode, s, g);
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Build a handle that is likely not live, in one of several ways
  task automatic make_bad_handle(output logic [gsa_pkg::SLOT_W-1:0] s,
                                 output logic [gsa_pkg::GEN_W-1:0] g);
    bit [gsa_pkg::SLOT_W-1:0] ls;
    bit [gsa_pkg::GEN_W-1:0]  lg;
    case ($urandom_range(0, 3))
      0: begin
        if (sb.pick_live(ls, lg)) begin
          s = ls;
          g = lg ^ (32'd1 << $urandom_range(0, 31));
        end else begin
          s = gsa_pkg::SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
          g = $urandom;
        end
      end
      1: begin
        s = (sb.slots_used > 0) ?
            gsa_pkg::SLOT_W'($urandom_range(0, sb.slots_used - 1)) : '0;
        g = sb.current_gen(s);
      end
      2: begin
        s = (sb.slots_used < TABLE_SLOTS) ?
            gsa_pkg::SLOT_W'($urandom_range(sb.slots_used, TABLE_SLOTS - 1)) :
            gsa_pkg::SLOT_W'($urandom_range(0, 1023));
        g = $urandom;
      end
      default: begin
        s = gsa_pkg::SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
        g = $urandom;
      end
    endcase
  endtask

  // One random operation; weights in percent, the rest are checks
  task automatic send_random(input int w_create, input int w_destroy, input int w_stale);
    int r;
    bit [gsa_pkg::SLOT_W-1:0] s;
    bit [gsa_pkg::GEN_W-1:0]  g;
    logic [gsa_pkg::SLOT_W-1:0] bs;
    logic [gsa_pkg::GEN_W-1:0]  bg;
    logic [gsa_pkg::MODE_W-1:0] chk_mode;
    r = $urandom_range(0, 99);
    if (r < w_create) begin
      send_op(gsa_pkg::MODE_CREATE, gsa_pkg::SLOT_W'($urandom_range(0, TABLE_SLOTS - 1)),
              $urandom);
    end else if (r < w_create + w_destroy) begin
      if (sb.pick_live(s, g)) send_op(gsa_pkg::MODE_DESTROY, s, g);
      else send_op(gsa_pkg::MODE_CREATE,
                   gsa_pkg::SLOT_W'($urandom_range(0, TABLE_SLOTS - 1)), $urandom);
    end else if (r < w_create + w_destroy + w_stale) begin
      make_bad_handle(bs, bg);
      send_op(gsa_pkg::MODE_DESTROY, bs, bg);
    end else begin
      chk_mode = ($urandom_range(0, 7) == 0) ? MODE_SPARE : gsa_pkg::MODE_CHECK;
      if ($urandom_range(0, 1) == 0 && sb.pick_live(s, g)) begin
        send_op(chk_mode, s, g);
      end else begin
        make_bad_handle(bs, bg);
        send_op(chk_mode, bs, bg);
      end
    end
  endtask

  // Hold the sender until every expected result has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: check each result transfer, then pick the next ready value
  initial begin : receiver
    int stall_left;
    int n;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
        hold_runs++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        n = gap_len();
        if (n == 0) begin
          out_tready <= 1'b1;
        end else begin
          stall_left = n - 1;
          out_tready <= 1'b0;
        end
      end
    end
  end

  // Watchdog on total run length
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, never-used slots, spare code
    send_op(gsa_pkg::MODE_CHECK,   10'd0,    32'd0);
    send_op(gsa_pkg::MODE_DESTROY, 10'd1023, 32'hFFFF_FFFF);
    send_op(MODE_SPARE,            10'd0,    32'd0);
    // Fresh slots, live and stale handles
    send_op(gsa_pkg::MODE_CREATE,  10'd1023, 32'hFFFF_FFFF);
    send_op(gsa_pkg::MODE_CREATE,  10'd0,    32'd0);
    send_op(gsa_pkg::MODE_CHECK,   10'd0,    32'd1);
    send_op(gsa_pkg::MODE_CHECK,   10'd0,    32'd2);
    send_op(gsa_pkg::MODE_DESTROY, 10'd0,    32'd2);
    send_op(gsa_pkg::MODE_DESTROY, 10'd0,    32'd1);
    send_op(gsa_pkg::MODE_DESTROY, 10'd0,    32'd2);
    send_op(gsa_pkg::MODE_CHECK,   10'd0,    32'd2);
    send_op(gsa_pkg::MODE_DESTROY, 10'd1,    32'd1);
    // Reuse from the free stack, most recently freed first
    send_op(gsa_pkg::MODE_CREATE,  10'd0,    32'd0);
    send_op(gsa_pkg::MODE_CREATE,  10'd0,    32'd0);
    send_op(gsa_pkg::MODE_CREATE,  10'd0,    32'd0);
    send_op(MODE_SPARE,            10'd1,    32'd2);
    send_op(gsa_pkg::MODE_CHECK,   10'd2,    32'd1);
    send_op(gsa_pkg::MODE_CHECK,   10'd3,    32'd0);
    send_op(gsa_pkg::MODE_DESTROY, 10'd1023, 32'd0);
    send_op(gsa_pkg::MODE_CHECK,   10'd512,  32'hAAAA_AAAA);
    send_op(gsa_pkg::MODE_DESTROY, 10'd2,    32'h8000_0001);

    // Mixed traffic, opening with a long receiver hold-off
    hold_req = 1'b1;
    repeat (350) send_random(45, 30, 10);
    wait_drained();

    // Fill the table to the brim, then knock on it while full
    for (int i = 0; i < 1300; i++) begin
      if (sb.slots_used == TABLE_SLOTS && sb.free_top == 0) break;
      send_random(92, 3, 0);
    end
    repeat (30) send_random(70, 0, 0);

    // Destroy-heavy traffic; the first stretch runs without idling
    no_idle = 1'b1;
    repeat (100) send_random(20, 50, 15);
    no_idle = 1'b0;
    repeat (300) send_random(20, 50, 15);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d creates (%0d reused, %0d full), %0d destroys, %0d stale handles",
             sb.n_create, sb.n_reuse, sb.n_full, sb.n_destroy, sb.n_stale);
    $display("Live checks %0d, peak live %0d, receiver hold-offs %0d, %0d cycles",
             sb.n_live_check, sb.peak_live, hold_runs, cycles);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
